// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/wsc_pkg.sv
// Shared types and constants of the window spread convergence detector.
package wsc_pkg;

  localparam int IN_W     = 16;
  localparam int NCH      = 3;
  localparam int SPREAD_W = 36;
  localparam int MIN_W    = 10;
  localparam int OUT_W    = 112;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 64;

  localparam logic [SPREAD_W-1:0] SPREAD_MAX  = {SPREAD_W{1'b1}};
  localparam logic [SPREAD_W-1:0] LIMIT_RESET = SPREAD_W'(8219689);
  localparam logic [MIN_W-1:0]    MIN_RESET   = MIN_W'(800);

  // Register selects, taken from the top address bit.
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_MIN   = 1'b1;

  localparam logic [1:0] CH_LAST = 2'(NCH - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_MUL_HH,
    ST_MUL_HL,
    ST_MUL_LL,
    ST_ACC_LL,
    ST_DIV,
    ST_SPREAD,
    ST_FIN
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD_OLD,
    OP_MUL_NEW,
    OP_MUL_OLD,
    OP_MUL_HH,
    OP_MUL_HL,
    OP_MUL_LL,
    OP_ACC_LL,
    OP_DIV,
    OP_SPREAD,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic converged;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic [SPREAD_W-1:0] dev_limit_sq;
    logic [MIN_W-1:0]    min_samples;
  } cfg_t;

endpackage

// File: rtl/wsc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module wsc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/wsc_regs.sv
// Configuration register file behind the APB-style port.
module wsc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsc_pkg::ADDR_W-1:0] paddr,
  input  logic [wsc_pkg::DATA_W-1:0] pwdata,
  output logic [wsc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output wsc_pkg::cfg_t              cfg
);
  import wsc_pkg::*;

  logic sel;
  logic wr;

  assign pready = 1'b1;
  assign sel    = paddr[ADDR_W-1];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev_limit_sq <= LIMIT_RESET;
      cfg.min_samples  <= MIN_RESET;
    end else if (wr) begin
      case (sel)
        REG_LIMIT: cfg.dev_limit_sq <= pwdata[SPREAD_W-1:0];
        REG_MIN:   cfg.min_samples  <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LIMIT: prdata = DATA_W'(cfg.dev_limit_sq);
      REG_MIN:   prdata = DATA_W'(cfg.min_samples);
      default:   prdata = '0;
    endcase
  end

endmodule

// File: rtl/wsc_ctrl.sv
// Sequencer that steps the datapath through one item and runs both handshakes.
module wsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  wsc_pkg::dp_stat_t stat,
  output wsc_pkg::dp_cmd_t  cmd
);
  import wsc_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic [1:0] ch;
  logic [1:0] ch_next;
  logic       m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ch       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      ch       <= ch_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    ch_next       = ch;
    m_tvalid_next = m_tvalid && !m_tready;
    s_tready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.ch        = ch;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_CAPTURE;
          // A converged block only reports its held values.
          state_next = stat.converged ? ST_FIN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.op     = OP_LOAD_OLD;
        ch_next    = '0;
        state_next = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        cmd.op     = OP_MUL_NEW;
        state_next = ST_MUL_OLD;
      end
      ST_MUL_OLD: begin
        cmd.op     = OP_MUL_OLD;
        state_next = ST_MUL_HH;
      end
      ST_MUL_HH: begin
        cmd.op     = OP_MUL_HH;
        state_next = ST_MUL_HL;
      end
      ST_MUL_HL: begin
        cmd.op     = OP_MUL_HL;
        state_next = ST_MUL_LL;
      end
      ST_MUL_LL: begin
        cmd.op     = OP_MUL_LL;
        state_next = ST_ACC_LL;
      end
      ST_ACC_LL: begin
        cmd.op     = OP_ACC_LL;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_done) begin
          state_next = ST_SPREAD;
        end
      end
      ST_SPREAD: begin
        cmd.op = OP_SPREAD;
        if (ch == CH_LAST) begin
          state_next = ST_FIN;
        end else begin
          ch_next    = ch + 2'd1;
          state_next = ST_MUL_NEW;
        end
      end
      ST_FIN: begin
        // Wait here until the output register is free or being emptied.
        if (!m_tvalid || m_tready) begin
          cmd.op        = OP_COMMIT;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/wsc_dp.sv
// Datapath: sample window, running sums, shared multiplier, divider and result register.
module wsc_dp #(
  parameter int WINDOW_LEN = 50,
  parameter int ANGLE_BITS = 16,
  parameter int COUNT_CAP  = 1000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wsc_pkg::dp_cmd_t                 cmd,
  input  wsc_pkg::cfg_t                    cfg,
  input  logic [wsc_pkg::NCH*wsc_pkg::IN_W-1:0] in_data,
  output wsc_pkg::dp_stat_t                stat,
  output logic                             ready_res,
  output logic [wsc_pkg::SPREAD_W-1:0]     roll_spread,
  output logic [wsc_pkg::SPREAD_W-1:0]     pitch_spread,
  output logic [wsc_pkg::SPREAD_W-1:0]     yaw_spread
);
  import wsc_pkg::*;

  localparam int POS_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = ANGLE_BITS + POS_W;
  localparam int SQ_RAW = 2 * ANGLE_BITS - 1 + POS_W;
  localparam int SQ_W   = (SQ_RAW > 64) ? 64 : SQ_RAW;
  localparam int MAG_W  = SUM_W;
  localparam int HALF   = (MAG_W + 1) / 2;
  localparam int HIGH_W = MAG_W - HALF;
  localparam int MW     = (ANGLE_BITS > HALF) ? ANGLE_BITS : HALF;
  localparam int PW     = (2 * MAG_W > 64) ? 64 : 2 * MAG_W;
  localparam int DIV_D  = (PW + 3) / 4;
  localparam int DIV_W  = 4 * DIV_D;
  localparam int DCNT_W = $clog2(DIV_D);
  localparam int RX_W   = POS_W + 4;
  localparam int CNT_W  = $clog2(COUNT_CAP + 1);
  localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;
  localparam int CW_A   = (DIV_W > SQ_W) ? DIV_W : SQ_W;
  localparam int CW     = (CW_A > SPREAD_W) ? CW_A : SPREAD_W;
  localparam int ROW_W  = NCH * ANGLE_BITS;

  function automatic logic [ANGLE_BITS-1:0] mag_of(input logic signed [ANGLE_BITS-1:0] v);
    return v[ANGLE_BITS-1] ? ANGLE_BITS'(-v) : ANGLE_BITS'(v);
  endfunction

  logic [POS_W-1:0]             pos;
  logic [WINDOW_LEN-1:0]        row_valid;
  logic [CNT_W-1:0]             count;
  logic                         converged;
  logic                         ok;
  logic signed [ANGLE_BITS-1:0] wide   [NCH];
  logic signed [ANGLE_BITS-1:0] new_s  [NCH];
  logic signed [ANGLE_BITS-1:0] old_s  [NCH];
  logic signed [SUM_W-1:0]      sums   [NCH];
  logic [SQ_W-1:0]              sqs    [NCH];
  logic [SPREAD_W-1:0]          hold   [NCH];
  logic [MAG_W-1:0]             mag;
  logic [MW-1:0]                mul_a;
  logic [MW-1:0]                mul_b;
  logic [2*MW-1:0]              prod;
  logic [DIV_W-1:0]             acc;
  logic [DIV_W-1:0]             quo;
  logic [POS_W-1:0]             rem;
  logic [DCNT_W-1:0]            div_cnt;
  logic [RX_W-1:0]              rx;
  logic [3:0]                   digit;
  logic [CW-1:0]                sq_c;
  logic [CW-1:0]                q_c;
  logic [CW-1:0]                diff;
  logic [SPREAD_W-1:0]          spread;
  logic                         conv_next;
  logic [ROW_W-1:0]             new_row;
  logic [ROW_W-1:0]             rd_row;
  logic                         ram_re;
  logic                         ram_we;

  // Samples narrower than the field are zero-extended; wider ones keep their low bits.
  for (genvar c = 0; c < NCH; c++) begin : g_widen
    if (ANGLE_BITS <= IN_W) begin : g_narrow
      assign wide[c] = in_data[c*IN_W +: ANGLE_BITS];
    end else begin : g_broad
      assign wide[c] = ANGLE_BITS'(in_data[c*IN_W +: IN_W]);
    end
    assign new_row[c*ANGLE_BITS +: ANGLE_BITS] = new_s[c];
  end

  assign ram_re = (cmd.op == OP_CAPTURE);
  assign ram_we = (cmd.op == OP_LOAD_OLD);

  wsc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(WINDOW_LEN)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos),
    .wdata(new_row),
    .re   (ram_re),
    .raddr(pos),
    .rdata(rd_row)
  );

  // Operand selection for the shared multiplier; the sum is squared in halves.
  always_comb begin
    case (cmd.op)
      OP_MUL_NEW: begin
        mul_a = MW'(mag_of(new_s[cmd.ch]));
        mul_b = MW'(mag_of(new_s[cmd.ch]));
      end
      OP_MUL_OLD: begin
        mul_a = MW'(mag_of(old_s[cmd.ch]));
        mul_b = MW'(mag_of(old_s[cmd.ch]));
      end
      OP_MUL_HH: begin
        mul_a = MW'(mag[MAG_W-1 -: HIGH_W]);
        mul_b = MW'(mag[MAG_W-1 -: HIGH_W]);
      end
      OP_MUL_HL: begin
        mul_a = MW'(mag[MAG_W-1 -: HIGH_W]);
        mul_b = MW'(mag[HALF-1:0]);
      end
      OP_MUL_LL: begin
        mul_a = MW'(mag[HALF-1:0]);
        mul_b = MW'(mag[HALF-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Radix-16 digit of the division by the window length.
  always_comb begin
    rx    = {rem, acc[DIV_W-1 -: 4]};
    digit = '0;
    for (int k = 1; k < 16; k++) begin
      if (rx >= RX_W'(k * WINDOW_LEN)) begin
        digit = 4'(k);
      end
    end
  end

  // The correction never exceeds the exact squared mean term, so the spread
  // is rounded up; an underflow only arises when the sums have wrapped.
  always_comb begin
    sq_c = CW'(sqs[cmd.ch]);
    q_c  = CW'(quo);
    diff = sq_c - q_c;
    if (sq_c < q_c) begin
      spread = '0;
    end else if (diff > CW'(SPREAD_MAX)) begin
      spread = SPREAD_MAX;
    end else begin
      spread = diff[SPREAD_W-1:0];
    end
  end

  assign conv_next = converged || (ok && (CMP_W'(count) >= CMP_W'(cfg.min_samples)));

  assign stat.converged = converged;
  assign stat.div_done  = (div_cnt == DCNT_W'(DIV_D - 1));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_CAPTURE: begin
        for (int c = 0; c < NCH; c++) begin
          new_s[c] <= wide[c];
        end
      end
      OP_LOAD_OLD: begin
        for (int c = 0; c < NCH; c++) begin
          old_s[c] <= row_valid[pos] ? rd_row[c*ANGLE_BITS +: ANGLE_BITS] : '0;
        end
      end
      OP_MUL_OLD: begin
        mag <= sums[cmd.ch][SUM_W-1] ? MAG_W'(-sums[cmd.ch]) : MAG_W'(sums[cmd.ch]);
      end
      OP_MUL_HH: begin
        rem <= '0;
      end
      OP_MUL_HL: begin
        acc <= DIV_W'(prod) << (2 * HALF);
      end
      OP_MUL_LL: begin
        acc <= acc + (DIV_W'(prod) << (HALF + 1));
      end
      OP_ACC_LL: begin
        acc <= acc + DIV_W'(prod);
      end
      OP_DIV: begin
        rem <= POS_W'(rx - RX_W'(digit * WINDOW_LEN));
        quo <= {quo[DIV_W-5:0], digit};
        acc <= acc << 4;
      end
      OP_COMMIT: begin
        ready_res    <= conv_next;
        roll_spread  <= hold[0];
        pitch_spread <= hold[1];
        yaw_spread   <= hold[2];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      row_valid <= '0;
      count     <= '0;
      converged <= 1'b0;
      ok        <= 1'b0;
      div_cnt   <= '0;
      for (int c = 0; c < NCH; c++) begin
        sums[c] <= '0;
        sqs[c]  <= '0;
        hold[c] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          ok <= 1'b1;
          if (!converged && (count != CNT_W'(COUNT_CAP))) begin
            count <= count + 1'b1;
          end
        end
        OP_LOAD_OLD: begin
          row_valid[pos] <= 1'b1;
        end
        OP_MUL_NEW: begin
          sums[cmd.ch] <= sums[cmd.ch] - SUM_W'(old_s[cmd.ch]) + SUM_W'(new_s[cmd.ch]);
        end
        OP_MUL_OLD: begin
          sqs[cmd.ch] <= sqs[cmd.ch] + SQ_W'(prod);
        end
        OP_MUL_HH: begin
          sqs[cmd.ch] <= sqs[cmd.ch] - SQ_W'(prod);
          div_cnt     <= '0;
        end
        OP_DIV: begin
          div_cnt <= div_cnt + 1'b1;
        end
        OP_SPREAD: begin
          hold[cmd.ch] <= spread;
          if ((spread == '0) || (spread > cfg.dev_limit_sq)) begin
            ok <= 1'b0;
          end
        end
        OP_COMMIT: begin
          if (!converged) begin
            pos       <= (pos == POS_W'(WINDOW_LEN - 1)) ? '0 : POS_W'(pos + 1'b1);
            converged <= conv_next;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/window_spread_convergence_detector.sv
// Window spread convergence detector: one roll, pitch and yaw sample (Q3.12)
// goes in per item and one result comes out per item, giving the latched
// convergence flag and the three window spreads in Q12.24. Each item passes
// through the one shared multiplier, which forms both sample squares and the
// squared sum in three half-width products per channel, and through the
// digit-serial division of that squared sum by the window length, done in
// ceil(min(64, 2 * (ANGLE_BITS + clog2(WINDOW_LEN))) / 4) radix-16 digits.
// Once convergence has latched an item skips the multiplier and divider. The
// window is a RAM of WINDOW_LEN rows with a valid flip-flop per row, so there
// is no clearing pass after reset. An output register lets the next item in
// while a result waits.
module window_spread_convergence_detector #(
  parameter int WINDOW_LEN = 50,
  parameter int ANGLE_BITS = 16,
  parameter int COUNT_CAP  = 1000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // roll_sample [15:0], pitch_sample [31:16], yaw_sample [47:32]
  input  logic [47:0]                s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // roll_spread [35:0], pitch_spread [71:36], yaw_spread [107:72], zero pad
  output logic [wsc_pkg::OUT_W-1:0]  m_tdata,
  // ready_res [0]
  output logic [0:0]                 m_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsc_pkg::ADDR_W-1:0] paddr,
  input  logic [wsc_pkg::DATA_W-1:0] pwdata,
  output logic [wsc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import wsc_pkg::*;

  cfg_t                cfg;
  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic                ready_res;
  logic [SPREAD_W-1:0] roll_spread;
  logic [SPREAD_W-1:0] pitch_spread;
  logic [SPREAD_W-1:0] yaw_spread;

  wsc_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  wsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  wsc_dp #(
    .WINDOW_LEN(WINDOW_LEN),
    .ANGLE_BITS(ANGLE_BITS),
    .COUNT_CAP (COUNT_CAP)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .in_data     (s_tdata),
    .stat        (stat),
    .ready_res   (ready_res),
    .roll_spread (roll_spread),
    .pitch_spread(pitch_spread),
    .yaw_spread  (yaw_spread)
  );

  assign m_tdata = {{(OUT_W - NCH*SPREAD_W){1'b0}}, yaw_spread, pitch_spread, roll_spread};
  assign m_tuser = ready_res;

endmodule

// File: rtl/wsc_checker.sv
// Port-level checks of the window spread convergence detector, bound to its top level.
`include "assert_macros.svh"

module wsc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [wsc_pkg::OUT_W-1:0] m_tdata,
  input logic [0:0]                m_tuser
);
  import wsc_pkg::*;

  logic seen_conv;

  // Set once a result reporting convergence has been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_conv <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser[0]) begin
      seen_conv <= 1'b1;
    end
  end

  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `ASSERT_NOW(a_conv_latched, m_tvalid && seen_conv, m_tuser[0])
  `ASSERT_NEXT(a_one_item_in_flight, s_tvalid && s_tready, !s_tready)
  `ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !m_tvalid)

endmodule

bind window_spread_convergence_detector wsc_checker u_checker (.*);
